// File: src/assert_macros.svh
// Assertion macros shared by the allocator modules.
// Include with the bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/bfa_pkg.sv
// Shared types and constants for the best-fit heap allocator.
// No dependencies.
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int MAX_FREE_DEF     = 64;
    localparam int MAX_USED_DEF     = 64;
    localparam int HEADER_BYTES_DEF = 32;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 2'd1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_LIMIT      = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_UNKNOWN    = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Micro-operations issued by the controller to the datapath
    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_CHK,
        CMD_A_RD,
        CMD_A_CMP,
        CMD_A_REM,
        CMD_A_DEC,
        CMD_U_WR,
        CMD_U_RD,
        CMD_U_CMP,
        CMD_F_RD,
        CMD_F_CMP,
        CMD_F_DEC,
        CMD_UR_RD,
        CMD_UR_WR,
        CMD_F_MRG,
        CMD_RM,
        CMD_SD_RD,
        CMD_SD_WR,
        CMD_INS,
        CMD_SU_RD,
        CMD_SU_WR
    } cmd_t;

    // Datapath status seen by the controller
    typedef struct packed {
        logic is_alloc;
        logic used_full;
        logic addr_zero;
        logic uc_zero;
        logic fc_zero;
        logic last_free;
        logic last_used;
        logic used_hit;
        logic above;
        logic found;
        logic small_rem;
        logic over_limit;
        logic no_room;
        logic merge_prev;
        logic merge_next;
        logic rm_end;
        logic ins_end;
    } sts_t;

endpackage

// File: src/bfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/bfa_ctrl.sv
// Allocator sequencer: one-hot state machine issuing datapath commands.
// Depends on bfa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bfa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  bfa_pkg::sts_t sts,
    output bfa_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done
);

    typedef enum logic [21:0] {
        S_IDLE  = 22'h000001,
        S_CHK   = 22'h000002,
        S_A_RD  = 22'h000004,
        S_A_CMP = 22'h000008,
        S_A_REM = 22'h000010,
        S_A_DEC = 22'h000020,
        S_U_WR  = 22'h000040,
        S_U_RD  = 22'h000080,
        S_U_CMP = 22'h000100,
        S_F_RD  = 22'h000200,
        S_F_CMP = 22'h000400,
        S_F_DEC = 22'h000800,
        S_UR_RD = 22'h001000,
        S_UR_WR = 22'h002000,
        S_F_MRG = 22'h004000,
        S_RM    = 22'h008000,
        S_SD_RD = 22'h010000,
        S_SD_WR = 22'h020000,
        S_INS   = 22'h040000,
        S_SU_RD = 22'h080000,
        S_SU_WR = 22'h100000,
        S_DONE  = 22'h200000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = bfa_pkg::CMD_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = bfa_pkg::CMD_LOAD;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                cmd = bfa_pkg::CMD_CHK;
                if (sts.is_alloc)
                begin
                    if (sts.used_full)     state_next = S_DONE;
                    else if (sts.fc_zero)  state_next = S_A_REM;
                    else                   state_next = S_A_RD;
                end
                else if (sts.addr_zero || sts.uc_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_U_RD;
                end
            end
            S_A_RD:
            begin
                cmd        = bfa_pkg::CMD_A_RD;
                state_next = S_A_CMP;
            end
            S_A_CMP:
            begin
                cmd        = bfa_pkg::CMD_A_CMP;
                state_next = sts.last_free ? S_A_REM : S_A_RD;
            end
            S_A_REM:
            begin
                cmd        = bfa_pkg::CMD_A_REM;
                state_next = S_A_DEC;
            end
            S_A_DEC:
            begin
                cmd = bfa_pkg::CMD_A_DEC;
                if (sts.found && sts.small_rem)  state_next = S_RM;
                else if (sts.found)              state_next = S_U_WR;
                else if (sts.over_limit)         state_next = S_DONE;
                else                             state_next = S_U_WR;
            end
            S_U_WR:
            begin
                cmd        = bfa_pkg::CMD_U_WR;
                state_next = S_DONE;
            end
            S_U_RD:
            begin
                cmd        = bfa_pkg::CMD_U_RD;
                state_next = S_U_CMP;
            end
            S_U_CMP:
            begin
                cmd = bfa_pkg::CMD_U_CMP;
                if (sts.used_hit)        state_next = sts.fc_zero ? S_F_DEC : S_F_RD;
                else if (sts.last_used)  state_next = S_DONE;
                else                     state_next = S_U_RD;
            end
            S_F_RD:
            begin
                cmd        = bfa_pkg::CMD_F_RD;
                state_next = S_F_CMP;
            end
            S_F_CMP:
            begin
                cmd        = bfa_pkg::CMD_F_CMP;
                state_next = (sts.above || sts.last_free) ? S_F_DEC : S_F_RD;
            end
            S_F_DEC:
            begin
                cmd        = bfa_pkg::CMD_F_DEC;
                state_next = sts.no_room ? S_DONE : S_UR_RD;
            end
            S_UR_RD:
            begin
                cmd        = bfa_pkg::CMD_UR_RD;
                state_next = S_UR_WR;
            end
            S_UR_WR:
            begin
                cmd        = bfa_pkg::CMD_UR_WR;
                state_next = (sts.merge_prev || sts.merge_next) ? S_F_MRG : S_INS;
            end
            S_F_MRG:
            begin
                cmd        = bfa_pkg::CMD_F_MRG;
                state_next = (sts.merge_prev && sts.merge_next) ? S_RM : S_DONE;
            end
            S_RM:
            begin
                cmd = bfa_pkg::CMD_RM;
                if (sts.rm_end)  state_next = sts.is_alloc ? S_U_WR : S_DONE;
                else             state_next = S_SD_RD;
            end
            S_SD_RD:
            begin
                cmd        = bfa_pkg::CMD_SD_RD;
                state_next = S_SD_WR;
            end
            S_SD_WR:
            begin
                cmd        = bfa_pkg::CMD_SD_WR;
                state_next = S_RM;
            end
            S_INS:
            begin
                cmd        = bfa_pkg::CMD_INS;
                state_next = sts.ins_end ? S_DONE : S_SU_RD;
            end
            S_SU_RD:
            begin
                cmd        = bfa_pkg::CMD_SU_RD;
                state_next = S_SU_WR;
            end
            S_SU_WR:
            begin
                cmd        = bfa_pkg::CMD_SU_WR;
                state_next = S_INS;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done, "accepted transaction did not go busy")
    `ASSERT_NEXT(a_done_idle, clk, rst_n, done, !busy, "not idle after result strobe")

endmodule

// File: src/bfa_dp.sv
// Allocator datapath: tables in RAM, counters, heap break, scan registers.
// Depends on bfa_pkg, bfa_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bfa_dp #(
    parameter int MAX_FREE     = bfa_pkg::MAX_FREE_DEF,
    parameter int MAX_USED     = bfa_pkg::MAX_USED_DEF,
    parameter int HEADER_BYTES = bfa_pkg::HEADER_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bfa_pkg::cmd_t                 cmd,
    input  logic                          opcode,
    input  logic [23:0]                   req_size,
    input  logic [31:0]                   block_address,
    input  logic                          cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output bfa_pkg::sts_t                 sts,
    output logic [31:0]                   result_address,
    output logic [1:0]                    status
);

    localparam int FCW = $clog2(MAX_FREE + 1);
    localparam int UCW = $clog2(MAX_USED + 1);
    localparam int FAW = $clog2(MAX_FREE);
    localparam int UAW = $clog2(MAX_USED);
    localparam int IW  = (FCW > UCW) ? FCW : UCW;
    localparam logic [31:0] HDR = 32'(HEADER_BYTES);

    // control state
    logic [FCW-1:0] fc_reg;
    logic [UCW-1:0] uc_reg;
    logic [IW-1:0]  idx_reg;
    logic [31:0]    heap_start_reg, heap_limit_reg, break_reg;
    logic           op_reg, addr_zero_reg, found_reg, mp_reg, mn_reg;
    logic [31:0]    result_reg;
    logic [1:0]     status_reg;

    // working payload
    logic [31:0]    need_reg, hdr_reg, len_reg, rem_reg, acc_reg;
    logic [31:0]    best_start_reg, best_len_reg;
    logic [31:0]    prev_start_reg, prev_len_reg, next_start_reg, next_len_reg;
    logic [IW-1:0]  best_idx_reg;
    logic [UAW-1:0] u_reg;
    logic [FCW-1:0] pos_reg;

    // RAM ports
    logic           f_we, f_re, u_we, u_re;
    logic [FAW-1:0] f_waddr, f_raddr;
    logic [UAW-1:0] u_waddr, u_raddr;
    logic [63:0]    f_wdata, f_rdata, u_wdata, u_rdata;
    logic [31:0]    f_rstart, f_rlen, u_rstart, u_rlen;

    bfa_ram #(.WIDTH(64), .DEPTH(MAX_FREE)) u_free_ram (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .re(f_re), .raddr(f_raddr), .rdata(f_rdata)
    );

    bfa_ram #(.WIDTH(64), .DEPTH(MAX_USED)) u_used_ram (
        .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
        .re(u_re), .raddr(u_raddr), .rdata(u_rdata)
    );

    assign f_rstart = f_rdata[63:32];
    assign f_rlen   = f_rdata[31:0];
    assign u_rstart = u_rdata[63:32];
    assign u_rlen   = u_rdata[31:0];

    // flags
    logic [IW:0]  idx_p1;
    logic [IW:0]  fc_x, uc_x;
    logic [32:0]  nb, prev_end, hdr_end;
    logic         fit, mp_c, mn_c, fc_full;
    logic [IW-1:0] idx_m1;

    assign idx_p1   = {1'b0, idx_reg} + 1'b1;
    assign idx_m1   = idx_reg - 1'b1;
    assign fc_x     = (IW + 1)'(fc_reg);
    assign uc_x     = (IW + 1)'(uc_reg);
    assign nb       = {1'b0, break_reg} + {1'b0, need_reg};
    assign prev_end = {1'b0, prev_start_reg} + {1'b0, prev_len_reg};
    assign hdr_end  = {1'b0, hdr_reg} + {1'b0, len_reg};
    assign fc_full  = (fc_reg == FCW'(MAX_FREE));
    assign fit      = (f_rlen >= need_reg) && (!found_reg || (f_rlen < best_len_reg));
    assign mp_c     = (pos_reg != '0) && (prev_end == {1'b0, hdr_reg});
    assign mn_c     = (pos_reg != fc_reg) && (hdr_end == {1'b0, next_start_reg});

    always_comb
    begin
        sts.is_alloc   = (op_reg == bfa_pkg::OP_ALLOC);
        sts.used_full  = (uc_reg == UCW'(MAX_USED));
        sts.addr_zero  = addr_zero_reg;
        sts.uc_zero    = (uc_reg == '0);
        sts.fc_zero    = (fc_reg == '0);
        sts.last_free  = (idx_p1 == fc_x);
        sts.last_used  = (idx_p1 == uc_x);
        sts.used_hit   = (u_rstart == hdr_reg);
        sts.above      = (f_rstart > hdr_reg);
        sts.found      = found_reg;
        sts.small_rem  = (rem_reg <= HDR);
        sts.over_limit = (nb > {1'b0, heap_limit_reg});
        sts.no_room    = !mp_c && !mn_c && fc_full;
        sts.merge_prev = mp_reg;
        sts.merge_next = mn_reg;
        sts.rm_end     = (idx_p1 >= fc_x);
        sts.ins_end    = (idx_reg == IW'(pos_reg));
    end

    // RAM access per micro-op
    always_comb
    begin
        f_we    = 1'b0;
        f_re    = 1'b0;
        f_waddr = idx_reg[FAW-1:0];
        f_raddr = idx_reg[FAW-1:0];
        f_wdata = f_rdata;
        u_we    = 1'b0;
        u_re    = 1'b0;
        u_waddr = u_reg;
        u_raddr = idx_reg[UAW-1:0];
        u_wdata = u_rdata;
        unique case (cmd)
            bfa_pkg::CMD_A_RD, bfa_pkg::CMD_F_RD:
            begin
                f_re = 1'b1;
            end
            bfa_pkg::CMD_A_DEC:
            begin
                f_we    = found_reg && !sts.small_rem;
                f_waddr = best_idx_reg[FAW-1:0];
                f_wdata = {best_start_reg, rem_reg};
            end
            bfa_pkg::CMD_U_WR:
            begin
                u_we    = 1'b1;
                u_waddr = uc_reg[UAW-1:0];
                u_wdata = {hdr_reg, len_reg};
            end
            bfa_pkg::CMD_U_RD:
            begin
                u_re = 1'b1;
            end
            bfa_pkg::CMD_UR_RD:
            begin
                u_re    = 1'b1;
                u_raddr = UAW'(uc_reg - 1'b1);
            end
            bfa_pkg::CMD_UR_WR:
            begin
                u_we = 1'b1;
            end
            bfa_pkg::CMD_F_MRG:
            begin
                f_we = 1'b1;
                if (mp_reg)
                begin
                    f_waddr = FAW'(pos_reg - 1'b1);
                    f_wdata = {prev_start_reg, acc_reg + (mn_reg ? next_len_reg : 32'd0)};
                end
                else
                begin
                    f_waddr = FAW'(pos_reg);
                    f_wdata = {hdr_reg, acc_reg};
                end
            end
            bfa_pkg::CMD_SD_RD:
            begin
                f_re    = 1'b1;
                f_raddr = idx_p1[FAW-1:0];
            end
            bfa_pkg::CMD_SD_WR, bfa_pkg::CMD_SU_WR:
            begin
                f_we = 1'b1;
            end
            bfa_pkg::CMD_INS:
            begin
                f_we    = sts.ins_end;
                f_wdata = {hdr_reg, len_reg};
            end
            bfa_pkg::CMD_SU_RD:
            begin
                f_re    = 1'b1;
                f_raddr = idx_m1[FAW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg         <= '0;
            uc_reg         <= '0;
            idx_reg        <= '0;
            heap_start_reg <= '0;
            heap_limit_reg <= '1;
            break_reg      <= '0;
            op_reg         <= bfa_pkg::OP_ALLOC;
            addr_zero_reg  <= 1'b0;
            found_reg      <= 1'b0;
            mp_reg         <= 1'b0;
            mn_reg         <= 1'b0;
            result_reg     <= '0;
            status_reg     <= bfa_pkg::ST_OK;
        end
        else
        begin
            unique case (cmd)
                bfa_pkg::CMD_LOAD:
                begin
                    op_reg        <= opcode;
                    addr_zero_reg <= (block_address == '0);
                    result_reg    <= '0;
                    status_reg    <= bfa_pkg::ST_OK;
                end
                bfa_pkg::CMD_CHK:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    if (op_reg == bfa_pkg::OP_ALLOC && sts.used_full)
                    begin
                        status_reg <= bfa_pkg::ST_TABLE_FULL;
                    end
                    else if (op_reg == bfa_pkg::OP_FREE && !addr_zero_reg && sts.uc_zero)
                    begin
                        status_reg <= bfa_pkg::ST_UNKNOWN;
                    end
                end
                bfa_pkg::CMD_A_CMP:
                begin
                    if (fit)
                    begin
                        found_reg <= 1'b1;
                    end
                    idx_reg <= idx_p1[IW-1:0];
                end
                bfa_pkg::CMD_A_DEC:
                begin
                    idx_reg <= best_idx_reg;
                    if (!found_reg)
                    begin
                        if (sts.over_limit)
                        begin
                            status_reg <= bfa_pkg::ST_LIMIT;
                        end
                        else
                        begin
                            break_reg <= nb[31:0];
                        end
                    end
                end
                bfa_pkg::CMD_U_WR:
                begin
                    uc_reg     <= uc_reg + 1'b1;
                    result_reg <= hdr_reg + HDR;
                end
                bfa_pkg::CMD_U_CMP:
                begin
                    if (sts.used_hit)
                    begin
                        idx_reg <= '0;
                    end
                    else
                    begin
                        idx_reg <= idx_p1[IW-1:0];
                        if (sts.last_used)
                        begin
                            status_reg <= bfa_pkg::ST_UNKNOWN;
                        end
                    end
                end
                bfa_pkg::CMD_F_CMP:
                begin
                    idx_reg <= idx_p1[IW-1:0];
                end
                bfa_pkg::CMD_F_DEC:
                begin
                    mp_reg <= mp_c;
                    mn_reg <= mn_c;
                    if (sts.no_room)
                    begin
                        status_reg <= bfa_pkg::ST_TABLE_FULL;
                    end
                end
                bfa_pkg::CMD_UR_RD:
                begin
                    uc_reg <= uc_reg - 1'b1;
                end
                bfa_pkg::CMD_UR_WR:
                begin
                    idx_reg <= IW'(fc_reg);
                end
                bfa_pkg::CMD_F_MRG:
                begin
                    idx_reg <= IW'(pos_reg);
                end
                bfa_pkg::CMD_RM:
                begin
                    if (sts.rm_end)
                    begin
                        fc_reg <= fc_reg - 1'b1;
                    end
                end
                bfa_pkg::CMD_SD_WR:
                begin
                    idx_reg <= idx_p1[IW-1:0];
                end
                bfa_pkg::CMD_INS:
                begin
                    if (sts.ins_end)
                    begin
                        fc_reg <= fc_reg + 1'b1;
                    end
                end
                bfa_pkg::CMD_SU_WR:
                begin
                    idx_reg <= idx_m1;
                end
                default:
                begin
                end
            endcase

            // config is to arrive only while idle; this block does not enforce it
            if (cfg_we)
            begin
                if (cfg_index == bfa_pkg::REG_HEAP_START)
                begin
                    heap_start_reg <= cfg_data;
                    break_reg      <= cfg_data;
                end
                else if (cfg_index == bfa_pkg::REG_HEAP_LIMIT)
                begin
                    heap_limit_reg <= cfg_data;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            bfa_pkg::CMD_LOAD:
            begin
                need_reg <= 32'(req_size) + HDR;
                hdr_reg  <= block_address - HDR;
            end
            bfa_pkg::CMD_A_CMP:
            begin
                if (fit)
                begin
                    best_idx_reg   <= idx_reg;
                    best_start_reg <= f_rstart;
                    best_len_reg   <= f_rlen;
                end
            end
            bfa_pkg::CMD_A_REM:
            begin
                rem_reg <= best_len_reg - need_reg;
            end
            bfa_pkg::CMD_A_DEC:
            begin
                if (found_reg && sts.small_rem)
                begin
                    hdr_reg <= best_start_reg;
                    len_reg <= best_len_reg;
                end
                else if (found_reg)
                begin
                    hdr_reg <= best_start_reg + rem_reg;
                    len_reg <= need_reg;
                end
                else
                begin
                    hdr_reg <= break_reg;
                    len_reg <= need_reg;
                end
            end
            bfa_pkg::CMD_U_CMP:
            begin
                if (sts.used_hit)
                begin
                    u_reg   <= idx_reg[UAW-1:0];
                    len_reg <= u_rlen;
                    pos_reg <= fc_reg;
                end
            end
            bfa_pkg::CMD_F_CMP:
            begin
                if (sts.above)
                begin
                    pos_reg        <= FCW'(idx_reg);
                    next_start_reg <= f_rstart;
                    next_len_reg   <= f_rlen;
                end
                else
                begin
                    prev_start_reg <= f_rstart;
                    prev_len_reg   <= f_rlen;
                    if (sts.last_free)
                    begin
                        pos_reg <= fc_reg;
                    end
                end
            end
            bfa_pkg::CMD_UR_WR:
            begin
                acc_reg <= (mp_reg ? prev_len_reg : next_len_reg) + len_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign result_address = result_reg;
    assign status         = status_reg;

    `ASSERT_ALWAYS(a_fc_range, clk, rst_n, fc_reg <= FCW'(MAX_FREE), "free count beyond table depth")
    `ASSERT_ALWAYS(a_uc_range, clk, rst_n, uc_reg <= UCW'(MAX_USED), "used count beyond table depth")
    `ASSERT_NEXT(a_uc_grow, clk, rst_n, cmd == bfa_pkg::CMD_U_WR, uc_reg != '0, "used count did not grow on grant")

endmodule

// File: src/best_fit_heap_allocator_unit.sv
// Top level of the best-fit heap allocator: sequencer plus datapath.
// Depends on bfa_pkg, bfa_ctrl, bfa_dp (and bfa_ram through bfa_dp).
`timescale 1ns / 1ps

// Best-fit heap allocator. Pulse start while busy is low to issue a
// transaction (opcode 0 allocate req_size bytes, opcode 1 free the payload
// at block_address). Exactly one result comes back per transaction: done
// is high for one cycle with result_address and status valid in that same
// cycle; the result cannot be held off, so capture it then. busy stays high
// from the cycle after acceptance until the result cycle has passed.
// The free and used tables live in single-write, single-read RAMs with
// registered reads. An allocate scans every free entry for the best fit;
// when a free block is consumed whole, the entries above it move down to
// close the gap. A free searches the used entries for the block, then the
// free entries for its place, and then either inserts it without merging,
// moving the entries above it up, merges it with one neighbour, or merges
// it with both and moves the entries above down. A null free or an empty
// used table goes straight to the result. Configuration writes (cfg_index
// 0 heap_start, also reloading the break; 1 heap_limit) are always ready
// and are to be issued only while the block is idle.
module best_fit_heap_allocator_unit #(
    parameter int MAX_FREE     = bfa_pkg::MAX_FREE_DEF,
    parameter int MAX_USED     = bfa_pkg::MAX_USED_DEF,
    parameter int HEADER_BYTES = bfa_pkg::HEADER_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // transaction in
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic [23:0]                   req_size,
    input  logic [31:0]                   block_address,
    // result out
    output logic                          done,
    output logic [31:0]                   result_address,
    output logic [1:0]                    status,
    // configuration write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    bfa_pkg::cmd_t cmd;
    bfa_pkg::sts_t sts;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    bfa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    bfa_dp #(
        .MAX_FREE     (MAX_FREE),
        .MAX_USED     (MAX_USED),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .opcode         (opcode),
        .req_size       (req_size),
        .block_address  (block_address),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sts            (sts),
        .result_address (result_address),
        .status         (status)
    );

endmodule

// File: test/bfa_result_checker.sv
// Watches the request, result and configuration channels of the allocator.
// Keeps its own model of the free/used tables and compares every result.
// Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          opcode,
    input  logic [23:0]                   req_size,
    input  logic [31:0]                   block_address,
    input  logic                          done,
    input  logic [31:0]                   result_address,
    input  logic [1:0]                    status,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output int                            errors,
    output int                            pending
);

    localparam int NFREE = bfa_pkg::MAX_FREE_DEF;
    localparam int NUSED = bfa_pkg::MAX_USED_DEF;
    localparam logic [31:0] HDR = 32'(bfa_pkg::HEADER_BYTES_DEF);

    typedef struct {
        logic [31:0] addr;
        logic [1:0]  st;
    } grant_t;

    grant_t      grant_q[$];
    logic [31:0] fr_base [NFREE];
    logic [31:0] fr_len  [NFREE];
    int          fr_n;
    logic [31:0] us_base [NUSED];
    logic [31:0] us_len  [NUSED];
    int          us_n;
    logic [31:0] brk;
    logic [31:0] lim;

    assign pending = grant_q.size();

    task automatic drop_free(input int idx);
        for (int i = idx; i + 1 < fr_n; i++)
        begin
            fr_base[i] = fr_base[i + 1];
            fr_len[i]  = fr_len[i + 1];
        end
        fr_n--;
    endtask

    task automatic model_alloc(input logic [23:0] size, output grant_t g);
        logic [31:0] need;
        logic [31:0] rem;
        logic [31:0] hdr;
        logic [31:0] len;
        logic [32:0] nb;
        int          best;
        need = {8'd0, size} + HDR;
        best = -1;
        g.addr = '0;
        if (us_n >= NUSED)
        begin
            g.st = bfa_pkg::ST_TABLE_FULL;
            return;
        end
        for (int i = 0; i < fr_n; i++)
            if (fr_len[i] >= need && (best < 0 || fr_len[i] < fr_len[best]))
                best = i;
        if (best >= 0)
        begin
            rem = fr_len[best] - need;
            if (rem <= HDR)
            begin
                hdr = fr_base[best];
                len = fr_len[best];
                drop_free(best);
            end
            else
            begin
                hdr = fr_base[best] + rem;
                len = need;
                fr_len[best] = rem;
            end
        end
        else
        begin
            nb = {1'b0, brk} + {1'b0, need};
            if (nb > {1'b0, lim})
            begin
                g.st = bfa_pkg::ST_LIMIT;
                return;
            end
            hdr = brk;
            len = need;
            brk = nb[31:0];
        end
        us_base[us_n] = hdr;
        us_len[us_n]  = len;
        us_n++;
        g.st   = bfa_pkg::ST_OK;
        g.addr = hdr + HDR;
    endtask

    task automatic model_free(input logic [31:0] addr, output grant_t g);
        logic [31:0] hdr;
        logic [31:0] len;
        int          u;
        int          pos;
        logic        mprev;
        logic        mnext;
        g.addr = '0;
        g.st   = bfa_pkg::ST_OK;
        if (addr == 32'd0)
            return;
        hdr = addr - HDR;
        u = -1;
        for (int i = 0; i < us_n; i++)
            if (u < 0 && us_base[i] == hdr)
                u = i;
        if (u < 0)
        begin
            g.st = bfa_pkg::ST_UNKNOWN;
            return;
        end
        len = us_len[u];
        pos = fr_n;
        for (int i = fr_n - 1; i >= 0; i--)
            if (fr_base[i] > hdr)
                pos = i;
        mprev = pos > 0 &&
                ({1'b0, fr_base[pos - 1]} + {1'b0, fr_len[pos - 1]}) == {1'b0, hdr};
        mnext = pos < fr_n && ({1'b0, hdr} + {1'b0, len}) == {1'b0, fr_base[pos]};
        if (!mprev && !mnext && fr_n >= NFREE)
        begin
            g.st = bfa_pkg::ST_TABLE_FULL;
            return;
        end
        us_n--;
        us_base[u] = us_base[us_n];
        us_len[u]  = us_len[us_n];
        if (mprev && mnext)
        begin
            fr_len[pos - 1] = fr_len[pos - 1] + len + fr_len[pos];
            drop_free(pos);
        end
        else if (mprev)
            fr_len[pos - 1] = fr_len[pos - 1] + len;
        else if (mnext)
        begin
            fr_base[pos] = hdr;
            fr_len[pos]  = fr_len[pos] + len;
        end
        else
        begin
            for (int i = fr_n; i > pos; i--)
            begin
                fr_base[i] = fr_base[i - 1];
                fr_len[i]  = fr_len[i - 1];
            end
            fr_base[pos] = hdr;
            fr_len[pos]  = len;
            fr_n++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grant_t g;
        grant_t exp_g;
        if (!rst_n)
        begin
            grant_q.delete();
            fr_n   = 0;
            us_n   = 0;
            brk    = '0;
            lim    = '1;
            errors = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == bfa_pkg::REG_HEAP_START)
                    brk = cfg_data;
                else if (cfg_index == bfa_pkg::REG_HEAP_LIMIT)
                    lim = cfg_data;
            end
            if (done)
            begin
                if (grant_q.size() == 0)
                begin
                    $display("%0t: unexpected result addr=%h status=%0d",
                             $time, result_address, status);
                    errors++;
                end
                else
                begin
                    exp_g = grant_q.pop_front();
                    if (result_address !== exp_g.addr)
                    begin
                        $display("%0t: result_address expected %h actual %h",
                                 $time, exp_g.addr, result_address);
                        errors++;
                    end
                    if (status !== exp_g.st)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_g.st, status);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (opcode == bfa_pkg::OP_ALLOC)
                    model_alloc(req_size, g);
                else
                    model_free(block_address, g);
                grant_q.push_back(g);
            end
        end
    end

endmodule

// File: test/tb_best_fit_heap_allocator_unit.sv
// Testbench top for the best-fit heap allocator: clock, reset, stimulus, verdict.
// Depends on bfa_pkg, best_fit_heap_allocator_unit and bfa_result_checker.
`timescale 1ns / 1ps

module tb_best_fit_heap_allocator_unit;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic                          opcode = bfa_pkg::OP_ALLOC;
    logic [23:0]                   req_size = '0;
    logic [31:0]                   block_address = '0;
    logic                          done;
    logic [31:0]                   result_address;
    logic [1:0]                    status;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index = bfa_pkg::REG_HEAP_START;
    logic [31:0]                   cfg_data = '0;
    int                            errors;
    int                            pending;

    // live payload pointers handed out by the block, and recently freed ones
    logic [31:0] live_q[$];
    logic [31:0] dead_q[$];
    logic [31:0] got_addr;
    logic [1:0]  got_st;
    int          burst_left;

    always #5 clk = ~clk;

    best_fit_heap_allocator_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .req_size       (req_size),
        .block_address  (block_address),
        .done           (done),
        .result_address (result_address),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    bfa_result_checker u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .req_size       (req_size),
        .block_address  (block_address),
        .done           (done),
        .result_address (result_address),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .errors         (errors),
        .pending        (pending)
    );

    // Hard stop: the run fails if it has not finished by this time.
    initial
    begin
        #60ms;
        $display("FAIL");
        $finish;
    end

    // One transaction: the block is idle on entry, so start is taken at the
    // next rising edge; drop start, then capture the single result in its
    // strobe cycle. Bursts run back to back; between bursts a random number
    // of idle cycles is usually inserted before start rises again.
    task automatic issue(input logic op, input logic [23:0] size, input logic [31:0] addr);
        int k;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        burst_left--;
        start         <= 1'b1;
        opcode        <= op;
        req_size      <= size;
        block_address <= addr;
        @(posedge clk);
        start <= 1'b0;
        @(negedge clk);
        while (!done)
            @(negedge clk);
        got_addr = result_address;
        got_st   = status;
        // the edge that ends the strobe cycle returns the block to idle
        @(posedge clk);
        // keep the pointer pool in step with what the block reports
        if (op == bfa_pkg::OP_ALLOC && got_st == bfa_pkg::ST_OK)
            live_q.push_back(got_addr);
        if (op == bfa_pkg::OP_FREE && got_st == bfa_pkg::ST_OK && addr != 32'd0)
        begin
            for (k = 0; k < live_q.size(); k++)
                if (live_q[k] == addr)
                begin
                    live_q.delete(k);
                    break;
                end
            dead_q.push_back(addr);
            if (dead_q.size() > 16)
                void'(dead_q.pop_front());
        end
    endtask

    // Register write, only ever issued with the block idle.
    task automatic write_reg(input logic [bfa_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_item();
        int          r;
        logic [23:0] sz;
        r = $urandom_range(0, 99);
        // lean towards freeing once many blocks are out
        if (live_q.size() > 48 && r < 55)
            r = r + 45;
        if (r < 55)
        begin
            case ($urandom_range(0, 19))
                0:       sz = 24'hFF_FFFF;
                1, 2:    sz = 24'($urandom);
                3:       sz = 24'd0;
                default: sz = 24'($urandom_range(0, 600));
            endcase
            issue(bfa_pkg::OP_ALLOC, sz, 32'($urandom));
        end
        else if (r < 90 && live_q.size() > 0)
            issue(bfa_pkg::OP_FREE, 24'($urandom), live_q[$urandom_range(0, live_q.size() - 1)]);
        else
        begin
            case ($urandom_range(0, 3))
                0:       issue(bfa_pkg::OP_FREE, 24'($urandom), 32'd0);
                1:       issue(bfa_pkg::OP_FREE, 24'($urandom), 32'($urandom));
                default: issue(bfa_pkg::OP_FREE, 24'($urandom),
                               dead_q.size() > 0 ? dead_q[$urandom_range(0, dead_q.size() - 1)]
                                                 : 32'hFFFF_FFFF);
            endcase
        end
    endtask

    task automatic random_phase(input int n);
        repeat (n)
            random_item();
    endtask

    initial
    begin
        logic [31:0] p_zero;
        logic [31:0] p_big;
        logic [31:0] p_a;
        logic [31:0] p_b;
        logic [31:0] p_lone;
        int          guard;
        burst_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // ---- directed: reset configuration ----
        issue(bfa_pkg::OP_ALLOC, 24'd0, '0);              p_zero = got_addr;
        issue(bfa_pkg::OP_ALLOC, 24'hFF_FFFF, '0);        p_big  = got_addr;
        issue(bfa_pkg::OP_ALLOC, 24'd100, '0);            p_a    = got_addr;
        issue(bfa_pkg::OP_ALLOC, 24'd100, '0);            p_b    = got_addr;
        issue(bfa_pkg::OP_FREE, 24'hFF_FFFF, 32'd0);      // null free
        issue(bfa_pkg::OP_FREE, '0, 32'hFFFF_FFFF);       // unknown pointer
        issue(bfa_pkg::OP_FREE, '0, p_b);                 // lone insert
        issue(bfa_pkg::OP_FREE, '0, p_a);                 // merges with block above
        issue(bfa_pkg::OP_FREE, '0, p_b);                 // double free
        issue(bfa_pkg::OP_ALLOC, 24'd50, '0);             // carved from high end
        issue(bfa_pkg::OP_ALLOC, 24'd150, '0);            // whole block taken
        issue(bfa_pkg::OP_FREE, '0, p_zero);              // heap start, no neighbour below
        issue(bfa_pkg::OP_ALLOC, 24'd1, '0);              // hole at heap start too small, grows the break
        issue(bfa_pkg::OP_FREE, '0, p_big);

        // explicit drain: nothing outstanding before the first random burst
        while (pending != 0)
            @(posedge clk);
        random_phase(400);

        // tight limit: break growth soon rejected
        write_reg(bfa_pkg::REG_HEAP_START, 32'h1000_0000);
        write_reg(bfa_pkg::REG_HEAP_LIMIT, 32'h1000_4E20);
        random_phase(350);

        // break close to the top of the address space: wrap is rejected
        write_reg(bfa_pkg::REG_HEAP_START, 32'hFFFF_0000);
        write_reg(bfa_pkg::REG_HEAP_LIMIT, 32'hFFFF_FFFF);
        random_phase(300);

        // zero limit: only existing free blocks can serve
        write_reg(bfa_pkg::REG_HEAP_START, 32'h0000_0000);
        write_reg(bfa_pkg::REG_HEAP_LIMIT, 32'h0000_0000);
        random_phase(250);

        write_reg(bfa_pkg::REG_HEAP_START, 32'hFFFF_FFFF);
        write_reg(bfa_pkg::REG_HEAP_LIMIT, 32'hFFFF_FFFF);
        random_phase(150);

        write_reg(bfa_pkg::REG_HEAP_START, 32'h0000_0100);
        random_phase(300);

        // ---- fill both tables ----
        // Give back everything, leave one lone block below a gap, then build
        // alternating free/used blocks above it until the free table is full.
        // A pointer the block refuses to take back is dropped from the pool.
        guard = 0;
        while (live_q.size() > 0 && guard < 256)
        begin
            issue(bfa_pkg::OP_FREE, '0, live_q[0]);
            if (got_st != bfa_pkg::ST_OK && live_q.size() > 0)
                void'(live_q.pop_front());
            guard++;
        end
        write_reg(bfa_pkg::REG_HEAP_START, 32'h4000_0000);
        issue(bfa_pkg::OP_ALLOC, 24'hFF_FFFF, '0);
        p_lone = got_addr;
        write_reg(bfa_pkg::REG_HEAP_START, 32'h8000_0000);
        for (int k = 0; k < 64; k++)
        begin
            issue(bfa_pkg::OP_ALLOC, 24'h80_0000 + 24'(k * 32'h2_0000), '0);
            p_a = got_addr;
            if (k < 63)
                issue(bfa_pkg::OP_ALLOC, 24'h80_0000 + 24'(k * 32'h2_0000 + 32'h1_0000), '0);
            issue(bfa_pkg::OP_FREE, '0, p_a);
        end
        issue(bfa_pkg::OP_FREE, '0, p_lone);              // no neighbour, free table full
        issue(bfa_pkg::OP_ALLOC, 24'd8, '0);              // used table full
        random_phase(100);

        guard = 0;
        while (pending != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (500) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
